### hdl/shs_pkg.sv
// shared types, constants and command/status structs of the shell sort unit
package shs_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned VW    = 32;

  typedef logic [CW-1:0] count_t;
  typedef logic [IW-1:0] addr_t;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [VW-1:0] sorted_value;
    logic                 is_final;
    logic                 overflow;
  } out_word_t;

  typedef enum logic [1:0] {
    RD_I,
    RD_JG,
    RD_K
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GAP_INIT,
    ST_GAP_CHK,
    ST_I_CHK,
    ST_HOLD_WAIT,
    ST_J_CHK,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } ctrl_state_e;

  typedef struct packed {
    logic    load;
    logic    rst_set;
    logic    gap_init;
    logic    gap_half;
    logic    i_init;
    logic    i_inc;
    logic    j_from_i;
    logic    cap_hold;
    logic    wr_shift;
    logic    wr_hold;
    logic    k_init;
    logic    k_inc;
    logic    out_load;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic gap_zero;
    logic i_end;
    logic j_ge_gap;
    logic greater;
    logic k_last;
  } status_t;

endpackage

### hdl/shell_sort_unit.sv
// top level of the shell sort unit: sequencer plus element datapath
//
// usage
//   input channel (in_valid_i / in_ready_o / in_word_i): one signed 32-bit
//   word per transfer; is_last closes the set. up to DEPTH words are kept,
//   later ones are dropped and the overflow bit is raised on the whole set.
//   output channel (out_valid_o / out_ready_i / out_word_o): the stored
//   words in ascending order, is_final on the last one.
// sequence
//   loading accepts one word per cycle. after the closing word the sort runs
//   halving-gap insertion passes on a store with one write port and a
//   registered read port: each step holds one element and shifts larger
//   entries one gap up until its place is found, then writes it there.
//   emission then reads each word, loads the output register and hands the
//   word over. one set is handled at a time; the input is closed from the
//   closing word until the final word of the set has been taken.
// reset
//   asynchronous, active low: the set is emptied and the unit waits for
//   input. the store needs no clearing, only written entries are read.
// stalls
//   a stalled receiver just holds the output word; nothing is lost.
module shell_sort_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  shs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output shs_pkg::out_word_t out_word_o
);

  // command and status between sequencer and datapath
  shs_pkg::cmd_t    cmd;
  shs_pkg::status_t status;

  shs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_is_last_i (in_word_i.is_last),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // store, counters, comparator and output register
  shs_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

### hdl/shs_datapath.sv
// element store, index counters, comparator and output register
module shs_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shs_pkg::cmd_t     cmd_i,
  input  shs_pkg::in_word_t in_word_i,
  output shs_pkg::status_t  status_o,
  output shs_pkg::out_word_t out_word_o
);

  logic signed [shs_pkg::VW-1:0] mem_q [shs_pkg::DEPTH];
  logic signed [shs_pkg::VW-1:0] rdata_q;
  logic signed [shs_pkg::VW-1:0] hold_q;
  shs_pkg::out_word_t            out_q;

  shs_pkg::count_t count_q, count_d;
  shs_pkg::count_t gap_q, gap_d;
  shs_pkg::count_t i_q, i_d;
  shs_pkg::count_t j_q, j_d;
  shs_pkg::count_t k_q, k_d;
  logic            dropped_q, dropped_d;

  shs_pkg::count_t jg;
  shs_pkg::count_t k_next;
  logic            full;
  logic            wr_en;
  shs_pkg::addr_t  wr_addr;
  shs_pkg::addr_t  rd_addr;
  logic signed [shs_pkg::VW-1:0] wr_data;

  assign full   = (count_q == shs_pkg::count_t'(shs_pkg::DEPTH));
  assign jg     = j_q - gap_q;
  assign k_next = k_q + shs_pkg::count_t'(1);

  // one write port: incoming word, shifted element, or held element
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_q[shs_pkg::IW-1:0];
    wr_data = hold_q;
    if (cmd_i.load && !full) begin
      wr_en   = 1'b1;
      wr_addr = count_q[shs_pkg::IW-1:0];
      wr_data = in_word_i.value;
    end else if (cmd_i.wr_shift) begin
      wr_en   = 1'b1;
      wr_data = rdata_q;
    end else if (cmd_i.wr_hold) begin
      wr_en   = 1'b1;
    end
  end

  always_comb begin
    unique case (cmd_i.rd_sel)
      shs_pkg::RD_I:  rd_addr = i_q[shs_pkg::IW-1:0];
      shs_pkg::RD_JG: rd_addr = jg[shs_pkg::IW-1:0];
      shs_pkg::RD_K:  rd_addr = k_q[shs_pkg::IW-1:0];
      default:        rd_addr = k_q[shs_pkg::IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    gap_d     = gap_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    if (cmd_i.load) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + shs_pkg::count_t'(1);
      end
    end
    if (cmd_i.rst_set) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end
    if (cmd_i.gap_init) gap_d = count_q >> 1;
    if (cmd_i.gap_half) gap_d = gap_q >> 1;
    if (cmd_i.i_init)   i_d   = gap_q;
    if (cmd_i.i_inc)    i_d   = i_q + shs_pkg::count_t'(1);
    if (cmd_i.j_from_i) j_d   = i_q;
    if (cmd_i.wr_shift) j_d   = jg;
    if (cmd_i.k_init)   k_d   = '0;
    if (cmd_i.k_inc)    k_d   = k_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      gap_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      gap_q     <= gap_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_hold) begin
      hold_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_q.sorted_value <= rdata_q;
      out_q.is_final     <= (k_next == count_q);
      out_q.overflow     <= dropped_q;
    end
  end

  assign status_o.gap_zero = (gap_q == '0);
  assign status_o.i_end    = (i_q == count_q);
  assign status_o.j_ge_gap = (j_q >= gap_q);
  assign status_o.greater  = (rdata_q > hold_q);
  assign status_o.k_last   = (k_next == count_q);
  assign out_word_o        = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= shs_pkg::count_t'(shs_pkg::DEPTH))
    else $error("element count beyond depth");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.load, cmd_i.wr_shift, cmd_i.wr_hold}))
    else $error("conflicting store writes");

  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dropped_q |-> full)
    else $error("drop flag set while store not full");

endmodule

### hdl/shs_ctrl.sv
// sequencer for loading, gapped insertion passes and emission
module shs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_is_last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  shs_pkg::status_t  status_i,
  output shs_pkg::cmd_t     cmd_o
);

  shs_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = shs_pkg::RD_K;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    unique case (state_q)
      shs_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_is_last_i) state_d = shs_pkg::ST_GAP_INIT;
        end
      end
      shs_pkg::ST_GAP_INIT: begin
        cmd_o.gap_init = 1'b1;
        state_d        = shs_pkg::ST_GAP_CHK;
      end
      shs_pkg::ST_GAP_CHK: begin
        if (status_i.gap_zero) begin
          cmd_o.k_init = 1'b1;
          state_d      = shs_pkg::ST_OUT_RD;
        end else begin
          cmd_o.i_init = 1'b1;
          state_d      = shs_pkg::ST_I_CHK;
        end
      end
      shs_pkg::ST_I_CHK: begin
        if (status_i.i_end) begin
          cmd_o.gap_half = 1'b1;
          state_d        = shs_pkg::ST_GAP_CHK;
        end else begin
          cmd_o.rd_sel   = shs_pkg::RD_I;
          cmd_o.j_from_i = 1'b1;
          state_d        = shs_pkg::ST_HOLD_WAIT;
        end
      end
      shs_pkg::ST_HOLD_WAIT: begin
        cmd_o.cap_hold = 1'b1;
        state_d        = shs_pkg::ST_J_CHK;
      end
      shs_pkg::ST_J_CHK: begin
        if (status_i.j_ge_gap) begin
          cmd_o.rd_sel = shs_pkg::RD_JG;
          state_d      = shs_pkg::ST_CMP;
        end else begin
          cmd_o.wr_hold = 1'b1;
          cmd_o.i_inc   = 1'b1;
          state_d       = shs_pkg::ST_I_CHK;
        end
      end
      shs_pkg::ST_CMP: begin
        if (status_i.greater) begin
          cmd_o.wr_shift = 1'b1;
          state_d        = shs_pkg::ST_J_CHK;
        end else begin
          cmd_o.wr_hold = 1'b1;
          cmd_o.i_inc   = 1'b1;
          state_d       = shs_pkg::ST_I_CHK;
        end
      end
      shs_pkg::ST_OUT_RD: begin
        cmd_o.rd_sel = shs_pkg::RD_K;
        state_d      = shs_pkg::ST_OUT_LD;
      end
      shs_pkg::ST_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = shs_pkg::ST_OUT_HOLD;
      end
      shs_pkg::ST_OUT_HOLD: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.k_last) begin
            cmd_o.rst_set = 1'b1;
            state_d       = shs_pkg::ST_LOAD;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = shs_pkg::ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = shs_pkg::ST_LOAD;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_sort_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == shs_pkg::ST_GAP_CHK && status_i.gap_zero) |=>
      (state_q == shs_pkg::ST_OUT_RD))
    else $error("emission did not follow the last pass");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.k_last) |=> (state_q == shs_pkg::ST_LOAD))
    else $error("no return to loading after final word");

endmodule
